// File: hw/rtl/assert_macros.svh
// assertion macros shared by the stencil sweep rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define FPSS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define FPSS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/fpss_pkg.sv
// shared types and constants of the five-point stencil sweep
package fpss_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int ROW_W    = 16;
    localparam int COL_W    = 11;
    localparam int GW_W     = 12;
    localparam int NSUM_W   = SAMPLE_W + 2;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_WEIGHT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOUR_WEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT      = 2'd3;

    // register reset values
    localparam logic [15:0]     RST_CENTER_WEIGHT    = 16'd6554;
    localparam logic [15:0]     RST_NEIGHBOUR_WEIGHT = 16'd14746;
    localparam logic [GW_W-1:0] RST_GRID_WIDTH       = 12'd512;
    localparam logic [15:0]     RST_GRID_HEIGHT      = 16'd512;

    // smallest usable grid dimension
    localparam int MIN_DIM = 3;

    // rounding constant for products with q0.16 weights
    localparam int ROUND_HALF = 32768;

    // result queue sizing
    localparam int MAX_RESULTS = 3;
    localparam int FIFO_DEPTH  = 16;
    localparam int FIFO_AW     = 4;
    localparam int FIFO_CW     = 5;

    // one result beat
    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic                done;
        logic                last;
    } t_result;

    // item after the line buffer read, heading for the blend pipeline
    typedef struct packed {
        logic [MAX_RESULTS-1:0] en;
        logic                   bord;
        logic                   done;
        logic [ROW_W-1:0]       row;
        logic [COL_W-1:0]       col;
        logic [SAMPLE_W-1:0]    center;
        logic [NSUM_W-1:0]      nsum;
        logic [SAMPLE_W-1:0]    b;
        logic [SAMPLE_W-1:0]    s;
    } t_stage;

    // up to three results pushed at once, in order
    typedef struct packed {
        logic [MAX_RESULTS-1:0]  en;
        t_result [MAX_RESULTS-1:0] res;
    } t_push;

endpackage

// File: hw/rtl/fpss_if.sv
// stream and configuration interfaces of the stencil sweep

// input samples
interface fpss_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

// result points
interface fpss_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] new_value;
    logic [15:0] out_row;
    logic [10:0] out_col;
    logic        grid_done;
    logic        run_last;
    modport source (output valid, output new_value, output out_row, output out_col,
                    output grid_done, output run_last, input ready);
    modport sink (input valid, input new_value, input out_row, input out_col,
                  input grid_done, input run_last, output ready);
endinterface

// register writes
interface fpss_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/five_point_stencil_sweep.sv
// throughput: one sample per cycle while the queue has room, set by the result queue giving one beat per cycle;
//   on the last grid row a sample yields one to three results (two for most columns),
//   so input then runs at the output rate; the line buffers take one read and one write
//   per cycle
// reset: counters, window, queue and weights return to defaults; line buffers keep contents
`include "assert_macros.svh"

module five_point_stencil_sweep #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fpss_in_if.sink      i_in,
    fpss_out_if.source   o_out,
    fpss_cfg_if.sink     i_cfg
);

    // configuration registers
    logic [15:0]                 r_center_weight;
    logic [15:0]                 r_neighbour_weight;
    logic [fpss_pkg::GW_W-1:0]   r_grid_width;
    logic [fpss_pkg::ROW_W-1:0]  r_grid_height;

    logic                        in_accept;
    logic                        cfg_accept;
    logic                        out_pop;
    logic [1:0]                  need;
    logic                        s2_valid;
    fpss_pkg::t_stage            s2;
    fpss_pkg::t_push             push;
    fpss_pkg::t_result           head;
    logic                        head_valid;
    logic [fpss_pkg::FIFO_CW-1:0] fifo_count;

    // queue slots held by results in the queue or still in the pipeline
    logic [fpss_pkg::FIFO_CW-1:0] r_used;
    logic [fpss_pkg::FIFO_CW-1:0] n_used;

    assign i_cfg.ready = i_rst_n;
    assign cfg_accept  = i_cfg.valid && i_cfg.ready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_weight    <= fpss_pkg::RST_CENTER_WEIGHT;
            r_neighbour_weight <= fpss_pkg::RST_NEIGHBOUR_WEIGHT;
            r_grid_width       <= fpss_pkg::RST_GRID_WIDTH;
            r_grid_height      <= fpss_pkg::RST_GRID_HEIGHT;
        end else if (cfg_accept) begin
            unique case (i_cfg.index)
                fpss_pkg::REG_CENTER_WEIGHT:    r_center_weight    <= i_cfg.data;
                fpss_pkg::REG_NEIGHBOUR_WEIGHT: r_neighbour_weight <= i_cfg.data;
                fpss_pkg::REG_GRID_WIDTH:       r_grid_width       <= i_cfg.data[11:0];
                fpss_pkg::REG_GRID_HEIGHT:      r_grid_height      <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // admit a sample only when the queue can take its worst case
    assign i_in.ready = i_rst_n
        && (r_used <= fpss_pkg::FIFO_CW'(fpss_pkg::FIFO_DEPTH - fpss_pkg::MAX_RESULTS));
    assign in_accept  = i_in.valid && i_in.ready;
    assign out_pop    = o_out.valid && o_out.ready;

    always_comb begin
        n_used = r_used + (in_accept ? fpss_pkg::FIFO_CW'(need) : '0)
               - fpss_pkg::FIFO_CW'(out_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    fpss_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_sample      (i_in.sample),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .o_need        (need),
        .o_s2_valid    (s2_valid),
        .o_s2          (s2)
    );

    fpss_blend u_blend (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_s2_valid         (s2_valid),
        .i_s2               (s2),
        .i_center_weight    (r_center_weight),
        .i_neighbour_weight (r_neighbour_weight),
        .o_push             (push)
    );

    fpss_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (out_pop),
        .o_valid (head_valid),
        .o_head  (head),
        .o_count (fifo_count)
    );

    // result beat
    assign o_out.valid     = head_valid;
    assign o_out.new_value = head.value;
    assign o_out.out_row   = head.row;
    assign o_out.out_col   = head.col;
    assign o_out.grid_done = head.done;
    assign o_out.run_last  = head.last;

    // checks
    `FPSS_ASSERT_IMP(a_credit_covers, i_clk, i_rst_n, 1'b1, r_used >= fifo_count, "slot count below queue fill")
    `FPSS_ASSERT_IMP(a_credit_bound, i_clk, i_rst_n, 1'b1, r_used <= fpss_pkg::FIFO_CW'(fpss_pkg::FIFO_DEPTH), "slot count beyond queue depth")
    `FPSS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready, o_out.valid && $stable(o_out.new_value), "result beat dropped or changed while waiting")

endmodule

// File: hw/rtl/fpss_window.sv
// raster position, line buffer memories and the neighbor window
module fpss_window #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [fpss_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [fpss_pkg::GW_W-1:0]   i_grid_width,
    input  logic [fpss_pkg::ROW_W-1:0]  i_grid_height,
    output logic [1:0]                  o_need,
    output logic                        o_s2_valid,
    output fpss_pkg::t_stage            o_s2
);

    localparam int CW = $clog2(MAX_WIDTH);

    // line buffers
    logic [fpss_pkg::SAMPLE_W-1:0] r_line_older  [MAX_WIDTH];
    logic [fpss_pkg::SAMPLE_W-1:0] r_line_recent [MAX_WIDTH];
    logic [fpss_pkg::SAMPLE_W-1:0] r_older_rd;
    logic [fpss_pkg::SAMPLE_W-1:0] r_recent_rd;

    // raster position
    logic [fpss_pkg::ROW_W-1:0] r_row;
    logic [CW-1:0]              r_col;
    logic [fpss_pkg::ROW_W-1:0] last_row;
    logic [CW-1:0]              last_col;
    logic [fpss_pkg::ROW_W-1:0] row_now;
    logic [CW-1:0]              col_now;
    logic                       en_blend;
    logic                       en_edge;
    logic                       en_border;

    // first stage: item waiting for its memory read
    logic                          r_s1_valid;
    logic [fpss_pkg::SAMPLE_W-1:0] r_s1_s;
    logic [CW-1:0]                 r_s1_c;
    logic [fpss_pkg::ROW_W-1:0]    r_s1_row;
    logic [2:0]                    r_s1_en;
    logic                          r_s1_bord;
    logic                          r_s1_done;
    logic                          r_s1_fwd;
    logic [fpss_pkg::SAMPLE_W-1:0] r_s1_fwd_data;

    // window: north, center, south of c-1 and center of c-2
    logic [fpss_pkg::SAMPLE_W-1:0] r_win_n;
    logic [fpss_pkg::SAMPLE_W-1:0] r_win_c;
    logic [fpss_pkg::SAMPLE_W-1:0] r_win_s;
    logic [fpss_pkg::SAMPLE_W-1:0] r_win_w;
    logic [fpss_pkg::SAMPLE_W-1:0] older_val;

    logic             r_s2_valid;
    fpss_pkg::t_stage r_s2;

    // effective grid size as last indexes
    always_comb begin
        if (32'(i_grid_width) > MAX_WIDTH) begin
            last_col = CW'(MAX_WIDTH - 1);
        end else if (32'(i_grid_width) < fpss_pkg::MIN_DIM) begin
            last_col = CW'(fpss_pkg::MIN_DIM - 1);
        end else begin
            last_col = CW'(i_grid_width - 12'd1);
        end
        if (32'(i_grid_height) < fpss_pkg::MIN_DIM) begin
            last_row = fpss_pkg::ROW_W'(fpss_pkg::MIN_DIM - 1);
        end else begin
            last_row = i_grid_height - 16'd1;
        end
    end

    // position clamped to the grid and the results it releases
    always_comb begin
        row_now   = (r_row > last_row) ? last_row : r_row;
        col_now   = (r_col > last_col) ? last_col : r_col;
        en_blend  = (row_now >= 16'd2) && (col_now != '0);
        en_edge   = (row_now >= 16'd2) && (col_now == last_col);
        en_border = (row_now == '0) || (row_now == last_row);
        o_need    = 2'(en_blend) + 2'(en_edge) + 2'(en_border);
    end

    // raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_accept) begin
            if (col_now == last_col) begin
                r_col <= '0;
                r_row <= (row_now == last_row) ? '0 : row_now + 16'd1;
            end else begin
                r_col <= col_now + CW'(1);
                r_row <= row_now;
            end
        end
    end

    // recent line: read old row, write new sample at the same column
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_recent_rd            <= r_line_recent[col_now];
            r_line_recent[col_now] <= i_sample;
        end
    end

    // older line: read at accept, write back the recent value in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_older_rd <= r_line_older[col_now];
        end
        if (r_s1_valid) begin
            r_line_older[r_s1_c] <= r_recent_rd;
        end
    end

    // first stage registers, with bypass when the write back hits the same column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
        end
        if (i_accept) begin
            r_s1_s        <= i_sample;
            r_s1_c        <= col_now;
            r_s1_row      <= row_now;
            r_s1_en       <= {en_border, en_edge, en_blend};
            r_s1_bord     <= (col_now == CW'(1));
            r_s1_done     <= (row_now == last_row) && (col_now == last_col);
            r_s1_fwd      <= r_s1_valid && (r_s1_c == col_now);
            r_s1_fwd_data <= r_recent_rd;
        end
    end

    assign older_val = r_s1_fwd ? r_s1_fwd_data : r_older_rd;

    // window shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_n <= '0;
            r_win_c <= '0;
            r_win_s <= '0;
            r_win_w <= '0;
        end else if (r_s1_valid) begin
            r_win_w <= r_win_c;
            r_win_n <= older_val;
            r_win_c <= r_recent_rd;
            r_win_s <= r_s1_s;
        end
    end

    // second stage: center and neighbor sum for the blend
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        if (r_s1_valid) begin
            r_s2.en     <= r_s1_en;
            r_s2.bord   <= r_s1_bord;
            r_s2.done   <= r_s1_done;
            r_s2.row    <= r_s1_row;
            r_s2.col    <= fpss_pkg::COL_W'(r_s1_c);
            r_s2.center <= r_win_c;
            r_s2.nsum   <= fpss_pkg::NSUM_W'(r_win_n) + fpss_pkg::NSUM_W'(r_win_s)
                         + fpss_pkg::NSUM_W'(r_recent_rd) + fpss_pkg::NSUM_W'(r_win_w);
            r_s2.b      <= r_recent_rd;
            r_s2.s      <= r_s1_s;
        end
    end

    assign o_s2_valid = r_s2_valid;
    assign o_s2       = r_s2;

endmodule

// File: hw/rtl/fpss_blend.sv
// weighted blend pipeline and result assembly
module fpss_blend (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s2_valid,
    input  fpss_pkg::t_stage i_s2,
    input  logic [15:0]      i_center_weight,
    input  logic [15:0]      i_neighbour_weight,
    output fpss_pkg::t_push  o_push
);

    logic             r_s3_valid;
    fpss_pkg::t_stage r_s3;
    logic [31:0]      r_p_center;
    logic [33:0]      r_p_neigh;
    logic [34:0]      acc;
    logic [18:0]      quot;
    logic [15:0]      blended;
    logic [2:0]       en;

    // products, one multiplier each
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= i_s2_valid;
        end
        if (i_s2_valid) begin
            r_s3       <= i_s2;
            r_p_center <= {16'd0, i_center_weight} * {16'd0, i_s2.center};
            r_p_neigh  <= {18'd0, i_neighbour_weight} * {16'd0, i_s2.nsum};
        end
    end

    // sum, round half up, saturate
    always_comb begin
        acc     = {3'd0, r_p_center} + {1'b0, r_p_neigh} + 35'(fpss_pkg::ROUND_HALF);
        quot    = acc[34:16];
        blended = (quot > 19'd65535) ? 16'hFFFF : quot[15:0];
    end

    // results in output order: interior point, end of row, border row point
    always_comb begin
        en = r_s3_valid ? r_s3.en : 3'b000;
        o_push.en = en;

        o_push.res[0].value = r_s3.bord ? r_s3.center : blended;
        o_push.res[0].row   = r_s3.row - 16'd1;
        o_push.res[0].col   = r_s3.col - 11'd1;
        o_push.res[0].done  = 1'b0;
        o_push.res[0].last  = en[0] && !en[1] && !en[2];

        o_push.res[1].value = r_s3.b;
        o_push.res[1].row   = r_s3.row - 16'd1;
        o_push.res[1].col   = r_s3.col;
        o_push.res[1].done  = 1'b0;
        o_push.res[1].last  = en[1] && !en[2];

        o_push.res[2].value = r_s3.s;
        o_push.res[2].row   = r_s3.row;
        o_push.res[2].col   = r_s3.col;
        o_push.res[2].done  = r_s3.done;
        o_push.res[2].last  = en[2];
    end

endmodule

// File: hw/rtl/fpss_result_fifo.sv
// result queue taking up to three beats a cycle and giving one
`include "assert_macros.svh"

module fpss_result_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fpss_pkg::t_push              i_push,
    input  logic                         i_pop,
    output logic                         o_valid,
    output fpss_pkg::t_result            o_head,
    output logic [fpss_pkg::FIFO_CW-1:0] o_count
);

    fpss_pkg::t_result                r_mem [fpss_pkg::FIFO_DEPTH];
    logic [fpss_pkg::FIFO_AW-1:0]     r_wr;
    logic [fpss_pkg::FIFO_AW-1:0]     r_rd;
    logic [fpss_pkg::FIFO_CW-1:0]     r_cnt;
    logic [1:0]                       off [fpss_pkg::MAX_RESULTS];
    logic [1:0]                       npush;
    logic                             pop;

    // packed write offsets of the enabled results
    always_comb begin
        off[0] = 2'd0;
        off[1] = 2'(i_push.en[0]);
        off[2] = 2'(i_push.en[0]) + 2'(i_push.en[1]);
        npush  = off[2] + 2'(i_push.en[2]);
        pop    = i_pop && (r_cnt != '0);
    end

    // storage
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < fpss_pkg::MAX_RESULTS; i++) begin
            if (i_push.en[i]) begin
                r_mem[fpss_pkg::FIFO_AW'(r_wr + fpss_pkg::FIFO_AW'(off[i]))] <= i_push.res[i];
            end
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + fpss_pkg::FIFO_AW'(npush);
            r_rd  <= r_rd + fpss_pkg::FIFO_AW'(pop);
            r_cnt <= r_cnt + fpss_pkg::FIFO_CW'(npush) - fpss_pkg::FIFO_CW'(pop);
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign o_count = r_cnt;

    // checks
    `FPSS_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, npush != 2'd0, (r_cnt + fpss_pkg::FIFO_CW'(npush)) <= fpss_pkg::FIFO_CW'(fpss_pkg::FIFO_DEPTH), "result queue overflow")
    `FPSS_ASSERT_NXT(a_pop_only, i_clk, i_rst_n, pop && (npush == 2'd0), r_cnt == $past(r_cnt) - 5'd1, "queue count wrong after a lone pop")
    `FPSS_ASSERT_NXT(a_wr_tracks, i_clk, i_rst_n, 1'b1, r_wr == $past(r_wr) + fpss_pkg::FIFO_AW'($past(npush)), "write pointer skipped")

endmodule
